/* rtl/lfsd_pkg.sv */
// Shared types, widths and constants for the line-follow steering decider.
// Used by the CORDIC unit, the divide-by-five unit and the top level.
package lfsd_pkg;

  // Datapath widths: CORDIC x/y carry the 16x scaled vector, angles are Q3.12.
  localparam int XW = 17;
  localparam int ZW = 16;
  localparam int NW = 17;

  // Divide by five as a multiply by round(2^18 / 5) and a shift.
  localparam int DIV_SHIFT = 18;
  localparam logic [16:0] DIV_RECIP = 17'd52429;

  typedef enum logic [2:0] {
    CMD_IDLE         = 3'd0,
    CMD_STRAFE_RIGHT = 3'd1,
    CMD_STRAFE_LEFT  = 3'd2,
    CMD_TURN_LEFT    = 3'd3,
    CMD_TURN_RIGHT   = 3'd4,
    CMD_FORWARD      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CENTER_COLUMN = 3'd0,
    REG_SIDE_LIMIT    = 3'd1,
    REG_ANGLE_LIMIT   = 3'd2,
    REG_TIMEOUT_MS    = 3'd3,
    REG_TICK_MS       = 3'd4
  } reg_idx_t;

  // round(atan(2^-i) * 4096) for the CORDIC micro-rotations.
  function automatic logic [11:0] atan_entry(input logic [3:0] idx);
    logic [11:0] val;
    case (idx)
      4'd0:    val = 12'd3217;
      4'd1:    val = 12'd1899;
      4'd2:    val = 12'd1003;
      4'd3:    val = 12'd509;
      4'd4:    val = 12'd256;
      4'd5:    val = 12'd128;
      4'd6:    val = 12'd64;
      4'd7:    val = 12'd32;
      4'd8:    val = 12'd16;
      4'd9:    val = 12'd8;
      4'd10:   val = 12'd4;
      4'd11:   val = 12'd2;
      4'd12:   val = 12'd1;
      default: val = 12'd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/lfsd_cordic.sv */
// Iterative vectoring CORDIC: one micro-rotation per cycle on shifters shared by all steps.
// Depends on lfsd_pkg for widths and the arctangent table.
module lfsd_cordic import lfsd_pkg::*; #(
  parameter int STEPS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [9:0]    y_in,
  input  logic        [8:0]    x_in,
  output logic                 done,
  output logic signed [ZW-1:0] angle
);

  localparam int CW = $clog2(STEPS + 1);

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [CW-1:0]        step;
  logic                 running;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] rot;

  always_comb begin
    dx  = y >>> step;
    dy  = x >>> step;
    rot = signed'({{(ZW-12){1'b0}}, atan_entry(step[3:0])});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        x       <= signed'({{(XW-13){1'b0}}, x_in, 4'b0000});
        y       <= signed'({{(XW-14){y_in[9]}}, y_in, 4'b0000});
        z       <= '0;
      end else if (running) begin
        // A zero residual leaves the vector where it is.
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + rot;
        end else if (y < 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - rot;
        end
        if (step == CW'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  assign angle = z;

endmodule

/* rtl/lfsd_div5.sv */
// Signed divide by five, truncating toward zero, through a reciprocal multiply.
// Depends on lfsd_pkg for widths and the reciprocal constant.
module lfsd_div5 import lfsd_pkg::*; (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [NW-1:0] num,
  output logic signed [ZW-1:0] quo
);

  logic [NW-1:0] mag_full;
  logic [15:0]   mag;
  logic [32:0]   prod;
  logic [14:0]   qmag;
  logic          neg;

  // The magnitude stays below 2^16, where the reciprocal is exact.
  always_comb begin
    mag_full = num[NW-1] ? NW'(-num) : NW'(num);
    mag      = mag_full[15:0];
    prod     = {17'd0, mag} * {16'd0, DIV_RECIP};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      qmag <= prod[DIV_SHIFT+14:DIV_SHIFT];
      neg  <= num[NW-1];
    end
  end

  assign quo = neg ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});

endmodule

/* rtl/line_follow_steering_decider.sv */
// Line-follow steering decider. A detection runs the CORDIC, two passes through the shared
// divide-by-five, the decision and the output stage; the first detection skips the two passes
// through the divider. A tick updates the timer and goes to the output stage. One item is in
// work at a time; its result is loaded once the output holds no unaccepted beat, and the next
// is taken the cycle after the result is loaded. Synchronous reset restores the register
// defaults and clears the averages, the timer and the command to idle.
module line_follow_steering_decider import lfsd_pkg::*; #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               action,
  input  logic [8:0]         line_column,
  input  logic [8:0]         line_row,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [2:0]         command,
  output logic signed [9:0]  smooth_offset,
  output logic signed [14:0] smooth_angle
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_DIV_OFF, ST_DIV_ANG, ST_DIV_WB, ST_DECIDE, ST_TICK, ST_DONE
  } state_t;

  state_t state;

  logic [8:0]  center_column;
  logic [8:0]  side_limit;
  logic [13:0] angle_limit;
  logic [15:0] timeout_ms;
  logic [7:0]  tick_ms;

  logic                 seen_once;
  logic signed [9:0]    offset_avg;
  logic signed [ZW-1:0] angle_avg;
  cmd_t                 current_command;
  logic [15:0]          time_left;
  logic signed [9:0]    off;

  logic                 accept;
  logic signed [9:0]    off_in;
  logic                 cordic_done;
  logic signed [ZW-1:0] cordic_angle;
  logic                 div_load;
  logic signed [NW-1:0] div_num;
  logic signed [ZW-1:0] div_quo;
  logic signed [NW-1:0] off_num;
  logic signed [NW-1:0] ang_num;
  logic                 wr_en;
  cmd_t                 cmd_next;

  assign pready     = 1'b1;
  assign wr_en      = psel & penable & pwrite;
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid & item_ready;
  assign off_in     = signed'({1'b0, line_column}) - signed'({1'b0, center_column});

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_CENTER_COLUMN: prdata = {23'd0, center_column};
      REG_SIDE_LIMIT:    prdata = {23'd0, side_limit};
      REG_ANGLE_LIMIT:   prdata = {18'd0, angle_limit};
      REG_TIMEOUT_MS:    prdata = {16'd0, timeout_ms};
      REG_TICK_MS:       prdata = {24'd0, tick_ms};
      default:           prdata = '0;
    endcase
  end

  // Numerators of (2*new + 3*old), fed one after the other to the divider.
  always_comb begin
    off_num  = NW'(2 * NW'(off)) + NW'(3 * NW'(offset_avg));
    ang_num  = NW'(2 * NW'(cordic_angle)) + NW'(3 * NW'(angle_avg));
    div_load = (state == ST_DIV_OFF) || (state == ST_DIV_ANG);
    div_num  = (state == ST_DIV_OFF) ? off_num : ang_num;
  end

  always_comb begin
    if (11'(offset_avg) > signed'({2'b00, side_limit})) begin
      cmd_next = CMD_STRAFE_RIGHT;
    end else if (11'(offset_avg) < -signed'({2'b00, side_limit})) begin
      cmd_next = CMD_STRAFE_LEFT;
    end else if (17'(angle_avg) < -signed'({3'b000, angle_limit})) begin
      cmd_next = CMD_TURN_LEFT;
    end else if (17'(angle_avg) > signed'({3'b000, angle_limit})) begin
      cmd_next = CMD_TURN_RIGHT;
    end else begin
      cmd_next = CMD_FORWARD;
    end
  end

  lfsd_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept & ~action),
    .y_in  (off_in),
    .x_in  (line_row),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  lfsd_div5 u_div5 (
    .clk  (clk),
    .load (div_load),
    .num  (div_num),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      center_column   <= 9'd172;
      side_limit      <= 9'd80;
      angle_limit     <= 14'd2048;
      timeout_ms      <= 16'd2000;
      tick_ms         <= 8'd10;
      seen_once       <= 1'b0;
      offset_avg      <= '0;
      angle_avg       <= '0;
      current_command <= CMD_IDLE;
      time_left       <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_CENTER_COLUMN: center_column <= pwdata[8:0];
          REG_SIDE_LIMIT:    side_limit    <= pwdata[8:0];
          REG_ANGLE_LIMIT:   angle_limit   <= pwdata[13:0];
          REG_TIMEOUT_MS:    timeout_ms    <= pwdata[15:0];
          REG_TICK_MS:       tick_ms       <= pwdata[7:0];
          default:           ;
        endcase
      end

      // In ST_DONE a taken beat is replaced by the new result below.
      if (result_valid && result_ready && state != ST_DONE) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            off   <= off_in;
            state <= action ? ST_TICK : ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cordic_done) begin
            if (seen_once) begin
              state <= ST_DIV_OFF;
            end else begin
              // The first detection loads the averages without smoothing.
              offset_avg <= off;
              angle_avg  <= cordic_angle;
              seen_once  <= 1'b1;
              state      <= ST_DECIDE;
            end
          end
        end
        ST_DIV_OFF: begin
          state <= ST_DIV_ANG;
        end
        ST_DIV_ANG: begin
          offset_avg <= div_quo[9:0];
          state      <= ST_DIV_WB;
        end
        ST_DIV_WB: begin
          angle_avg <= div_quo;
          state     <= ST_DECIDE;
        end
        ST_DECIDE: begin
          current_command <= cmd_next;
          time_left       <= timeout_ms;
          state           <= ST_DONE;
        end
        ST_TICK: begin
          if (time_left <= {8'd0, tick_ms}) begin
            time_left       <= '0;
            current_command <= CMD_IDLE;
          end else begin
            time_left <= time_left - {8'd0, tick_ms};
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            command       <= current_command;
            smooth_offset <= offset_avg;
            smooth_angle  <= angle_avg[14:0];
            result_valid  <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/tb_steering_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the line-follow steering decider bench: predicts the command and the
// smoothed offset and angle for every accepted beat. Depends on lfsd_pkg for cmd_t and reg_idx_t.
package tb_steering_pkg;
  import lfsd_pkg::*;

  localparam int CORDIC_ROT = 14;
  localparam int ATAN_Q12 [16] = '{3217, 1899, 1003, 509, 256, 128, 64, 32,
                                   16, 8, 4, 2, 1, 0, 0, 0};

  typedef struct {
    cmd_t               cmd;
    logic signed [9:0]  offset;
    logic signed [14:0] angle;
  } steer_t;

  class steering_scoreboard;
    int unsigned center_col = 172;
    int unsigned side_lim = 80;
    int unsigned angle_lim = 2048;
    int unsigned timeout_lim = 2000;
    int unsigned tick_step = 10;

    bit   seen_line;
    int   offset_avg;
    int   angle_avg;
    int   time_left;
    cmd_t steer_cmd = CMD_IDLE;

    steer_t expected_steer[$];
    int errors;
    int checked;
    int detections;
    int ticks;
    int cmd_hits[6];

    function int unsigned write_setting(reg_idx_t idx, int unsigned val);
      int unsigned kept;
      case (idx)
        REG_CENTER_COLUMN: begin
          kept = val & 32'h1FF;
          center_col = kept;
        end
        REG_SIDE_LIMIT: begin
          kept = val & 32'h1FF;
          side_lim = kept;
        end
        REG_ANGLE_LIMIT: begin
          kept = val & 32'h3FFF;
          angle_lim = kept;
        end
        REG_TIMEOUT_MS: begin
          kept = val & 32'hFFFF;
          timeout_lim = kept;
        end
        REG_TICK_MS: begin
          kept = val & 32'hFF;
          tick_step = kept;
        end
        default: kept = 0;
      endcase
      return kept;
    endfunction

    // Vectoring CORDIC on the 16x scaled vector; the angle accumulates in Q3.12.
    function int heading(int dy, int dx);
      int x, y, z, sx, sy;
      x = dx * 16;
      y = dy * 16;
      z = 0;
      for (int i = 0; i < CORDIC_ROT; i++) begin
        sx = y >>> i;
        sy = x >>> i;
        if (y > 0) begin
          x = x + sx;
          y = y - sy;
          z += ATAN_Q12[i];
        end else if (y < 0) begin
          x = x - sx;
          y = y + sy;
          z -= ATAN_Q12[i];
        end
      end
      return z;
    endfunction

    function void take_item(bit act, logic [8:0] col, logic [8:0] row);
      int off, ang;
      steer_t e;
      if (!act) begin
        detections++;
        off = int'(col) - int'(center_col);
        ang = heading(off, int'(row));
        if (seen_line) begin
          offset_avg = (2 * off + 3 * offset_avg) / 5;
          angle_avg = (2 * ang + 3 * angle_avg) / 5;
        end else begin
          offset_avg = off;
          angle_avg = ang;
          seen_line = 1'b1;
        end
        time_left = int'(timeout_lim);
        if (offset_avg > int'(side_lim))
          steer_cmd = CMD_STRAFE_RIGHT;
        else if (offset_avg < -int'(side_lim))
          steer_cmd = CMD_STRAFE_LEFT;
        else if (angle_avg < -int'(angle_lim))
          steer_cmd = CMD_TURN_LEFT;
        else if (angle_avg > int'(angle_lim))
          steer_cmd = CMD_TURN_RIGHT;
        else
          steer_cmd = CMD_FORWARD;
      end else begin
        ticks++;
        time_left -= int'(tick_step);
        if (time_left <= 0) begin
          time_left = 0;
          steer_cmd = CMD_IDLE;
        end
      end
      e.cmd = steer_cmd;
      e.offset = offset_avg[9:0];
      e.angle = angle_avg[14:0];
      expected_steer.push_back(e);
    endfunction

    function void check_steer(logic [2:0] cmd, logic signed [9:0] off,
                              logic signed [14:0] ang);
      steer_t e;
      if (expected_steer.size() == 0) begin
        $error("result beat with no expectation waiting: command %0d", cmd);
        errors++;
        return;
      end
      e = expected_steer.pop_front();
      checked++;
      cmd_hits[int'(e.cmd)]++;
      if (cmd !== e.cmd) begin
        $error("command: expected %0d, got %0d", e.cmd, cmd);
        errors++;
      end
      if (off !== e.offset) begin
        $error("smooth_offset: expected %0d, got %0d", e.offset, off);
        errors++;
      end
      if (ang !== e.angle) begin
        $error("smooth_angle: expected %0d, got %0d", e.angle, ang);
        errors++;
      end
    endfunction

    function int pending();
      return expected_steer.size();
    endfunction
  endclass

endpackage

/* bench/tb_line_follow_steering_decider.sv */
`timescale 1ns / 100ps
// Top-level bench for line_follow_steering_decider: directed and random detection and tick
// beats under random stalls, register settings over APB. Depends on lfsd_pkg and tb_steering_pkg.
module tb_line_follow_steering_decider;
  import lfsd_pkg::*;
  import tb_steering_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_ready;
  logic action = 1'b0;
  logic [8:0] line_column = '0;
  logic [8:0] line_row = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [2:0] command;
  logic signed [9:0] smooth_offset;
  logic signed [14:0] smooth_angle;

  steering_scoreboard sb;
  bit calm;
  int rx_wait;
  int reg_errors;
  int reg_writes;

  line_follow_steering_decider #(.CORDIC_STEPS(CORDIC_ROT)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready),
    .action(action), .line_column(line_column), .line_row(line_row),
    .result_valid(result_valid), .result_ready(result_ready),
    .command(command), .smooth_offset(smooth_offset), .smooth_angle(smooth_angle)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : rx_stall
    int hold;
    if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      result_ready <= 1'b0;
    end else begin
      hold = pick_gap();
      result_ready <= (hold == 0);
      rx_wait <= (hold > 0) ? hold - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_steer(command, smooth_offset, smooth_angle);
  end

  task automatic send_item(input bit act, input logic [8:0] col, input logic [8:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    line_column <= col;
    line_row <= row;
    do @(posedge clk); while (!item_ready);
    sb.take_item(act, col, row);
  endtask

  // Holds the sender off until every outstanding beat has come back.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write, then read the register back in the same APB selection.
  task automatic write_reg(input reg_idx_t idx, input int unsigned val);
    int unsigned kept;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    kept = sb.write_setting(idx, val);
    reg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) begin
      $error("register %s: expected %0d, got %0d", idx.name(), kept, prdata);
      reg_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned cc, input int unsigned sl,
                                input int unsigned al, input int unsigned to,
                                input int unsigned tk);
    write_reg(REG_CENTER_COLUMN, cc);
    write_reg(REG_SIDE_LIMIT, sl);
    write_reg(REG_ANGLE_LIMIT, al);
    write_reg(REG_TIMEOUT_MS, to);
    write_reg(REG_TICK_MS, tk);
  endtask

  // Runs of detections, about half clustered around the strafe thresholds, and runs of ticks
  // long enough to reach the timeout where the settings allow it.
  task automatic random_traffic(input int n);
    int sent, kind, burst, span, c, r, expiry;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          if ($urandom_range(0, 1)) begin
            span = int'(sb.side_lim) + 8;
            c = int'(sb.center_col) + int'($urandom_range(0, 2 * span)) - span;
            if (c < 0) c = 0;
            if (c > 511) c = 511;
          end else begin
            c = $urandom_range(0, 511);
          end
          r = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 15) : $urandom_range(0, 511);
          send_item(1'b0, c[8:0], r[8:0]);
          sent++;
        end
      end else if (kind < 96) begin
        expiry = int'(sb.timeout_lim / ((sb.tick_step == 0) ? 1 : sb.tick_step)) + 2;
        if (expiry > 40) expiry = 40;
        burst = $urandom_range(1, expiry);
        repeat (burst) begin
          send_item(1'b1, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
          sent++;
        end
      end else begin
        drain();
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a tick before any line, then the first detection loads directly.
    send_item(1'b1, 9'd511, 9'd511);
    send_item(1'b0, 9'd172, 9'd0);
    send_item(1'b0, 9'd0, 9'd511);
    send_item(1'b0, 9'd511, 9'd511);
    send_item(1'b0, 9'd511, 9'd0);
    send_item(1'b0, 9'd0, 9'd0);
    send_item(1'b0, 9'd172, 9'd511);
    send_item(1'b0, 9'd180, 9'd1);
    send_item(1'b0, 9'd164, 9'd1);
    send_item(1'b0, 9'd0, 9'd1);
    send_item(1'b1, 9'd0, 9'd0);
    drain();

    // Short timeout: three ticks run the timer down to zero and the command drops to idle.
    write_reg(REG_TIMEOUT_MS, 25);
    send_item(1'b0, 9'd250, 9'd300);
    repeat (4) send_item(1'b1, 9'd85, 9'd170);
    drain();

    // A zero tick step holds the timer; with a zero timeout it expires at once.
    write_reg(REG_TICK_MS, 0);
    send_item(1'b0, 9'd172, 9'd100);
    send_item(1'b1, 9'd172, 9'd100);
    drain();
    write_reg(REG_TIMEOUT_MS, 0);
    send_item(1'b0, 9'd172, 9'd100);
    send_item(1'b1, 9'd172, 9'd100);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 2 || ph == 6);
      case (ph)
        0: apply_settings(0, 0, 0, 0, 1);
        1: apply_settings(511, 511, 12868, 65535, 255);
        2: apply_settings(172, 80, 2048, 2000, 10);
        3: apply_settings(511, 0, 0, 1, 255);
        4: apply_settings(0, 511, 12868, 300, 1);
        default: apply_settings($urandom_range(100, 400), $urandom_range(0, 120),
                                $urandom_range(0, 6000), $urandom_range(0, 300),
                                $urandom_range(1, 60));
      endcase
      random_traffic(123);
      drain();
    end
    calm = 0;

    // Let any stray result beat show up before closing.
    repeat (2 * (CORDIC_ROT + 6)) @(posedge clk);

    $display("Checked %0d results from %0d detections and %0d ticks across %0d register writes.",
             sb.checked, sb.detections, sb.ticks, reg_writes);
    $display("Expected commands: idle %0d, strafe %0d, turn %0d, forward %0d.",
             sb.cmd_hits[CMD_IDLE], sb.cmd_hits[CMD_STRAFE_RIGHT] + sb.cmd_hits[CMD_STRAFE_LEFT],
             sb.cmd_hits[CMD_TURN_LEFT] + sb.cmd_hits[CMD_TURN_RIGHT], sb.cmd_hits[CMD_FORWARD]);
    if (sb.errors == 0 && reg_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
rtl/lfsd_pkg.sv
rtl/lfsd_cordic.sv
rtl/lfsd_div5.sv
rtl/line_follow_steering_decider.sv
bench/tb_steering_pkg.sv
bench/tb_line_follow_steering_decider.sv
